// ===== hw/rtl/atc_pkg.sv =====
package atc_pkg;

  localparam int unsigned POS_BITS_DEF = 24;

  localparam logic [15:0] GEAR_RESET = 16'd1000;
  localparam logic [15:0] TOL_RESET  = 16'd5;
  localparam logic [15:0] MILLE      = 16'd1000;
  localparam logic [15:0] UNCAL      = 16'd9999;

  // cycle tracker flag bits
  localparam int unsigned TRK_SEEN  = 6;
  localparam int unsigned TRK_ARMED = 7;

  localparam logic [1:0] ZONE_CLOSED = 2'b01;
  localparam logic [1:0] ZONE_SHORT  = 2'b11;
  localparam logic [1:0] ENDS_BOTH   = 2'b11;

  typedef enum logic [2:0] {
    CMD_UPDATE      = 3'd0,
    CMD_SET_CLOSE   = 3'd1,
    CMD_CLR_CLOSE   = 3'd2,
    CMD_SET_OPEN    = 3'd3,
    CMD_CLR_OPEN    = 3'd4,
    CMD_OPEN_REVS   = 3'd5,
    CMD_CLOSE_REVS  = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_GEAR     = 3'd0,
    CFG_SHIFT    = 3'd1,
    CFG_TOL      = 3'd2,
    CFG_REVERSED = 3'd3,
    CFG_LOCK     = 3'd4
  } cfg_idx_e;

endpackage

// ===== hw/rtl/atc_div.sv =====
module atc_div #(
  parameter int unsigned DvdW = 47,
  parameter int unsigned DvsW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DvsW-1:0] rem_q, dvs_q;
  logic [DvdW-1:0] quo_q;
  logic [DvsW:0]   trial;
  logic            fits;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem_q, quo_q[DvdW-1]};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
      quo_q <= {quo_q[DvdW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hw/rtl/actuator_travel_calibration_core.sv =====
// actuator travel calibration core
// input channel (in_valid_i/in_ready_o) takes one transaction of command, encoder
// position and revolutions; each transaction gives exactly one result transaction
// on the output channel (out_valid_o/out_ready_i) holding ways, per-mille position,
// zone, calibration status, cancel flag and cycle count.
// configuration writes use cfg_valid_i/cfg_ready_o with a register index and data;
// cfg_ready_o is always high; the user must see that writes go in only while the
// core is idle, the block itself does not enforce it. set/clear, refused,
// zero-revolution and unused commands and an update with no end set run no
// division; a revolutions command, an update with one end set and the first
// update with both ends set run one division, a calibrated update two (DvdW is
// 47 at the default position width). the shared restoring divider, one quotient
// bit a cycle, serves revolutions-to-counts, counts-to-revolutions and per-mille.
// one transaction is in flight at a time: in_ready_o is high only when idle, in
// the cycle after the result is taken, and while the receiver stalls the result is
// held and no new input is taken.
// reset clears end points, flags, ways, cycle tracker and counter, and loads the
// configuration defaults (gear ratio 1000, tolerance 5).
module actuator_travel_calibration_core #(
  parameter int unsigned PosBits = atc_pkg::POS_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic [23:0]        abs_position_i,
  input  logic [15:0]        revolutions_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] percent_position_o,
  output logic signed [15:0] current_way_o,
  output logic [15:0]        full_way_o,
  output logic [1:0]         zone_o,
  output logic [1:0]         calib_status_o,
  output logic               cancelled_o,
  output logic [15:0]        cycle_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned MaW  = (PosBits + 1 > 16) ? PosBits + 1 : 16;
  localparam int unsigned PrW  = MaW + 16;
  localparam int unsigned DvdW = (PrW > 47) ? PrW : 47;
  localparam int unsigned DvsW = (PosBits > 16) ? PosBits : 16;
  localparam int unsigned LnW  = PosBits + 2;

  typedef logic [PosBits-1:0]     pos_t;
  typedef logic signed [LnW-1:0]  line_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_DSTART = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_POST   = 8'b0010_0000,
    S_CYCLE  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    PH_REVS = 2'd0,
    PH_FULL = 2'd1,
    PH_WAY  = 2'd2,
    PH_PCT  = 2'd3
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q;

  // configuration
  logic [15:0] gear_q, tol_q;
  logic [3:0]  shift_q;
  logic        rev_q, lock_q;

  // calibration state
  pos_t               close_q, open_q, full_travel_q, mid_q;
  logic [1:0]         end_flags_q, zone_q;
  logic [15:0]        full_way_q, cycle_counter_q;
  logic signed [15:0] current_way_q, percent_q;
  logic [7:0]         tracker_q;
  logic               cancel_q;

  // transaction holding
  atc_pkg::cmd_e cmd_q;
  pos_t          pos_q;
  logic [15:0]   revs_q;
  logic          neg_q;
  logic [MaW-1:0] mul_a_q;
  logic [15:0]   mul_b_q;
  logic [PrW-1:0] prod_q;

  // divider
  logic            div_start, div_done;
  logic [DvdW-1:0] div_dvd, div_quot;
  logic [DvsW-1:0] div_dvs;

  atc_div #(.DvdW(DvdW), .DvsW(DvsW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign div_start = (state_q == S_DSTART);

  always_comb begin
    case (phase_q)
      PH_REVS: div_dvs = DvsW'(atc_pkg::MILLE);
      PH_PCT:  div_dvs = DvsW'(full_travel_q);
      default: div_dvs = (gear_q == '0) ? DvsW'(1) : DvsW'(gear_q);
    endcase
    if (phase_q == PH_REVS) div_dvd = DvdW'(prod_q) << shift_q;
    else                    div_dvd = DvdW'(prod_q);
  end

  // mirrored positions
  pos_t pos_m, cl_m, op_m;
  always_comb begin
    pos_m = rev_q ? pos_t'(0 - pos_q)   : pos_q;
    cl_m  = rev_q ? pos_t'(0 - close_q) : close_q;
    op_m  = rev_q ? pos_t'(0 - open_q)  : open_q;
  end

  // travel from closed end on calibrated update, and from the set end with one end set
  line_t line_cal, line_abs;
  pos_t  line_one;
  always_comb begin
    line_cal = line_t'({2'b00, pos_m}) - line_t'({2'b00, cl_m});
    if (cl_m > mid_q) begin
      if (pos_m < mid_q) line_cal = line_cal + line_t'({2'b01, {PosBits{1'b0}}});
    end else begin
      if (pos_m > mid_q) line_cal = line_cal - line_t'({2'b01, {PosBits{1'b0}}});
    end
    line_abs = line_cal[LnW-1] ? -line_cal : line_cal;
    line_one = end_flags_q[0] ? pos_t'(pos_m - cl_m) : pos_t'(op_m - pos_m);
  end

  // post-processing: counts to revolutions, per-mille clamp, zone, midpoint and revolutions to counts
  logic [15:0]        smask;
  logic [DvdW:0]      qsh;
  logic signed [15:0] cw, pct, pct_cl;
  logic [15:0]        fw;
  logic signed [17:0] cw_x, tol_x, hi_x;
  logic [1:0]         zone_cal;
  logic [PosBits:0]   mid_sum;
  pos_t               mid_new, rev_d;
  always_comb begin
    smask = (16'd1 << shift_q) - 16'd1;
    if (neg_q) qsh = ({1'b0, div_quot} + (DvdW + 1)'(smask)) >> shift_q;
    else       qsh = {1'b0, div_quot} >> shift_q;
    if (!neg_q) cw = (qsh > (DvdW + 1)'(32767)) ? 16'sh7fff : $signed(qsh[15:0]);
    else        cw = (qsh > (DvdW + 1)'(32768)) ? 16'sh8000 : $signed(16'(0 - qsh[15:0]));
    fw = (qsh > (DvdW + 1)'(65535)) ? 16'hffff : qsh[15:0];
    cw_x = {{2{cw[15]}}, cw};
    tol_x = $signed({2'b00, tol_q});
    hi_x = $signed({2'b00, full_way_q}) - tol_x;
    zone_cal = {cw_x >= hi_x, cw_x <= tol_x};
    if (!neg_q) pct = (div_quot > DvdW'(32767)) ? 16'sh7fff : $signed(div_quot[15:0]);
    else        pct = (div_quot > DvdW'(32768)) ? 16'sh8000
                                                : $signed(16'(0 - div_quot[15:0]));
    pct_cl = pct;
    if (zone_q[0] && pct_cl > 16'sd0) pct_cl = 16'sd0;
    if (zone_q[1] && pct_cl < $signed(atc_pkg::MILLE)) pct_cl = $signed(atc_pkg::MILLE);
    mid_sum = {1'b0, op_m} + {1'b0, cl_m};
    mid_new = mid_sum[PosBits:1];
    if (op_m >= cl_m) mid_new = mid_new + {1'b0, {(PosBits - 1){1'b1}}};
    rev_d = div_quot[PosBits-1:0];
  end

  // open-close cycle tracking
  logic [7:0]  trk_d;
  logic [15:0] cnt_d;
  always_comb begin
    trk_d = tracker_q;
    cnt_d = cycle_counter_q;
    if (end_flags_q == 2'b00) begin
      trk_d = '0;
    end else if (zone_q != 2'b00) begin
      if (trk_d == '0 && zone_q != atc_pkg::ZONE_SHORT) trk_d = {6'd0, zone_q};
      if (zone_q == trk_d[1:0]) begin
        if (!trk_d[atc_pkg::TRK_SEEN]) begin
          trk_d[atc_pkg::TRK_SEEN] = 1'b1;
          if (trk_d[atc_pkg::TRK_ARMED]) begin
            cnt_d = cnt_d + 16'd1;
            trk_d[atc_pkg::TRK_ARMED] = 1'b0;
          end
        end
      end else if (trk_d[atc_pkg::TRK_SEEN]) begin
        trk_d[atc_pkg::TRK_SEEN]  = 1'b0;
        trk_d[atc_pkg::TRK_ARMED] = 1'b1;
      end
    end
  end

  logic need_revs, refuse_revs, refuse_set_cl, refuse_set_op;
  always_comb begin
    need_revs     = (revs_q != '0);
    refuse_revs   = (end_flags_q != 2'b00) || lock_q;
    refuse_set_cl = end_flags_q[0] || lock_q;
    refuse_set_op = end_flags_q[1] || lock_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        state_d = S_OUT;
        case (cmd_q)
          atc_pkg::CMD_UPDATE: begin
            if (end_flags_q == 2'b00) state_d = S_CYCLE;
            else                      state_d = S_MUL;
          end
          atc_pkg::CMD_OPEN_REVS, atc_pkg::CMD_CLOSE_REVS: begin
            if (need_revs && !refuse_revs) state_d = S_MUL;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_MUL:    state_d = S_DSTART;
      S_DSTART: state_d = S_DIV;
      S_DIV:    if (div_done) state_d = S_POST;
      S_POST: begin
        case (phase_q)
          PH_REVS: state_d = S_OUT;
          PH_WAY:  state_d = (end_flags_q == atc_pkg::ENDS_BOTH) ? S_MUL : S_CYCLE;
          default: state_d = S_CYCLE;
        endcase
      end
      S_CYCLE:  state_d = S_OUT;
      S_OUT:    if (out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q <= atc_pkg::GEAR_RESET;
      shift_q <= '0;
      tol_q <= atc_pkg::TOL_RESET;
      rev_q <= 1'b0;
      lock_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        atc_pkg::CFG_GEAR:     gear_q  <= cfg_data_i;
        atc_pkg::CFG_SHIFT:    shift_q <= cfg_data_i[3:0];
        atc_pkg::CFG_TOL:      tol_q   <= cfg_data_i;
        atc_pkg::CFG_REVERSED: rev_q   <= cfg_data_i[0];
        atc_pkg::CFG_LOCK:     lock_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q  <= atc_pkg::cmd_e'(command_i);
      pos_q  <= pos_t'(abs_position_i);
      revs_q <= revolutions_i;
    end
    if (state_q == S_MUL) prod_q <= PrW'(mul_a_q * mul_b_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_q <= '0;
      open_q <= '0;
      full_travel_q <= '0;
      mid_q <= '0;
      end_flags_q <= '0;
      zone_q <= '0;
      full_way_q <= '0;
      cycle_counter_q <= '0;
      current_way_q <= '0;
      percent_q <= '0;
      tracker_q <= '0;
      cancel_q <= 1'b0;
      phase_q <= PH_REVS;
      neg_q <= 1'b0;
      mul_a_q <= '0;
      mul_b_q <= '0;
    end else begin
      case (state_q)
        S_DECODE: begin
          case (cmd_q)
            atc_pkg::CMD_UPDATE: begin
              mul_b_q <= atc_pkg::MILLE;
              if (end_flags_q == atc_pkg::ENDS_BOTH) begin
                if (full_travel_q == '0) begin
                  phase_q <= PH_FULL;
                  neg_q <= 1'b0;
                  mul_a_q <= MaW'(pos_t'(op_m - cl_m));
                end else begin
                  phase_q <= PH_WAY;
                  neg_q <= line_cal[LnW-1];
                  mul_a_q <= MaW'(line_abs[PosBits:0]);
                end
              end else begin
                percent_q <= $signed(atc_pkg::UNCAL);
                full_way_q <= atc_pkg::UNCAL;
                full_travel_q <= '0;
                phase_q <= PH_WAY;
                neg_q <= 1'b0;
                mul_a_q <= MaW'(line_one);
                if (end_flags_q == 2'b00) begin
                  current_way_q <= $signed(atc_pkg::UNCAL);
                  zone_q <= '0;
                end
              end
            end
            atc_pkg::CMD_SET_CLOSE: begin
              if (refuse_set_cl) cancel_q <= 1'b1;
              else begin
                close_q <= pos_q;
                end_flags_q[0] <= 1'b1;
              end
            end
            atc_pkg::CMD_CLR_CLOSE: begin
              if (lock_q) cancel_q <= 1'b1;
              else begin
                close_q <= '0;
                end_flags_q[0] <= 1'b0;
              end
            end
            atc_pkg::CMD_SET_OPEN: begin
              if (refuse_set_op) cancel_q <= 1'b1;
              else begin
                open_q <= pos_q;
                end_flags_q[1] <= 1'b1;
              end
            end
            atc_pkg::CMD_CLR_OPEN: begin
              if (lock_q) cancel_q <= 1'b1;
              else begin
                open_q <= '0;
                end_flags_q[1] <= 1'b0;
              end
            end
            atc_pkg::CMD_OPEN_REVS, atc_pkg::CMD_CLOSE_REVS: begin
              if (need_revs) begin
                if (refuse_revs) cancel_q <= 1'b1;
                phase_q <= PH_REVS;
                mul_a_q <= MaW'(revs_q);
                mul_b_q <= gear_q;
              end
            end
            default: ;
          endcase
        end
        S_POST: begin
          case (phase_q)
            PH_REVS: begin
              end_flags_q <= atc_pkg::ENDS_BOTH;
              if (cmd_q == atc_pkg::CMD_OPEN_REVS) begin
                close_q <= pos_q;
                open_q <= rev_q ? pos_t'(pos_q - rev_d) : pos_t'(pos_q + rev_d);
              end else begin
                open_q <= pos_q;
                close_q <= rev_q ? pos_t'(pos_q + rev_d) : pos_t'(pos_q - rev_d);
              end
            end
            PH_FULL: begin
              full_way_q <= fw;
              if ({1'b0, fw[15:1]} <= tol_q || mul_a_q == '0) begin
                full_travel_q <= '0;
                zone_q <= atc_pkg::ZONE_SHORT;
              end else begin
                full_travel_q <= mul_a_q[PosBits-1:0];
                mid_q <= mid_new;
                zone_q <= '0;
              end
            end
            PH_WAY: begin
              current_way_q <= cw;
              if (end_flags_q == atc_pkg::ENDS_BOTH) begin
                zone_q <= zone_cal;
                phase_q <= PH_PCT;
              end else begin
                zone_q <= zone_cal[0] ? end_flags_q : 2'b00;
              end
            end
            default: percent_q <= pct_cl;
          endcase
        end
        S_CYCLE: begin
          tracker_q <= trk_d;
          cycle_counter_q <= cnt_d;
        end
        default: ;
      endcase
    end
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = (state_q == S_OUT);
  assign cfg_ready_o        = 1'b1;
  assign percent_position_o = percent_q;
  assign current_way_o      = current_way_q;
  assign full_way_o         = full_way_q;
  assign zone_o             = zone_q;
  assign calib_status_o     = end_flags_q;
  assign cancelled_o        = cancel_q;
  assign cycle_count_o      = cycle_counter_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_no_take_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  a_pct_needs_both_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POST && phase_q == PH_PCT) |-> end_flags_q == atc_pkg::ENDS_BOTH)
    else $error("per-mille divide without both end points");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside wait state");

endmodule

// ===== tb/atc_checker.sv =====
`timescale 1ns / 1ps

module atc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         command_i,
  input  logic [23:0]        abs_position_i,
  input  logic [15:0]        revolutions_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] percent_position_i,
  input  logic signed [15:0] current_way_i,
  input  logic [15:0]        full_way_i,
  input  logic [1:0]         zone_i,
  input  logic [1:0]         calib_status_i,
  input  logic               cancelled_i,
  input  logic [15:0]        cycle_count_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam longint PosMask = (64'sd1 <<< 24) - 1;

  typedef struct packed {
    logic [15:0] pct;
    logic [15:0] cway;
    logic [15:0] fway;
    logic [1:0]  zone;
    logic [1:0]  ends;
    logic        cancel;
    logic [15:0] cycles;
  } status_t;

  status_t status_q[$];

  // configuration copy
  longint gear, shift, tol, rev_dir, lock;
  // calibration state
  longint close_pt, open_pt, ends, full_trav, mid_pt, trav_close;
  longint full_way_r, cur_way_r, pct_r, tracker, cycles, cancel_r, zone_r;

  function automatic bit allowed(longint cond);
    if ((ends & cond) != 0 || lock != 0) begin
      cancel_r = 1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint counts_to_revs(longint counts);
    longint ratio, q;
    ratio = (gear != 0) ? gear : 1;
    q = (counts * 1000) / ratio;
    if (q >= 0) return q >>> shift;
    // rounds toward minus infinity on the negative side
    return -((-q + ((64'sd1 <<< shift) - 1)) >>> shift);
  endfunction

  function automatic longint revs_to_counts(longint r);
    return ((r * gear) <<< shift) / 1000;
  endfunction

  function automatic void travel_update(longint pos_in);
    longint pos, cl, op, zn, fw, mid, line, cw, pct;
    pos = pos_in;
    cl = close_pt;
    op = open_pt;
    zn = 0;
    if (rev_dir != 0) begin
      pos = (-pos) & PosMask;
      cl = (-cl) & PosMask;
      op = (-op) & PosMask;
    end
    if (ends == 3) begin
      if (full_trav == 0) begin
        full_trav = (op - cl) & PosMask;
        fw = counts_to_revs(full_trav);
        if (fw > 65535) fw = 65535;
        full_way_r = fw;
        if ((full_way_r >>> 1) <= tol) full_trav = 0;
        if (full_trav == 0) begin
          zn = 3;
        end else begin
          mid = (op + cl) >>> 1;
          if (op >= cl) mid += PosMask >>> 1;
          mid_pt = mid & PosMask;
        end
      end else begin
        line = pos - cl;
        if (cl > mid_pt) begin
          if (pos < mid_pt) line += PosMask + 1;
        end else begin
          if (pos > mid_pt) line -= PosMask + 1;
        end
        trav_close = line;
        cw = sat16(counts_to_revs(line));
        cur_way_r = cw;
        if (cw <= tol) zn |= 1;
        if (cw >= full_way_r - tol) zn |= 2;
        pct = sat16((line * 1000) / full_trav);
        if ((zn & 1) != 0 && pct > 0) pct = 0;
        if ((zn & 2) != 0 && pct < 1000) pct = 1000;
        pct_r = pct;
      end
    end else begin
      pct_r = 9999;
      full_way_r = 9999;
      full_trav = 0;
      if (ends == 0) begin
        cur_way_r = 9999;
      end else begin
        if ((ends & 1) != 0) line = (pos - cl) & PosMask;
        else line = (op - pos) & PosMask;
        trav_close = line;
        cw = sat16(counts_to_revs(line));
        cur_way_r = cw;
        if (cw <= tol) zn |= ends;
      end
    end
    zone_r = zn;
  endfunction

  function automatic void count_cycles();
    if (ends == 0) begin
      tracker = 0;
      return;
    end
    if (zone_r == 0) return;
    if (tracker == 0 && zone_r != 3) tracker = zone_r;
    if (zone_r == (tracker & 3)) begin
      if ((tracker & 'h40) != 0) return;
      tracker |= 'h40;
      if ((tracker & 'h80) != 0) begin
        cycles = (cycles + 1) & 'hFFFF;
        tracker &= ~longint'('h80);
      end
    end else if ((tracker & 'h40) != 0) begin
      tracker &= ~longint'('h40);
      tracker |= 'h80;
    end
  endfunction

  function automatic status_t predict_status(logic [2:0] cmd_raw, logic [23:0] pos_raw,
                                             logic [15:0] revs_raw);
    longint pos, r, d;
    status_t s;
    pos = longint'(pos_raw) & PosMask;
    r = longint'(revs_raw);
    case (atc_pkg::cmd_e'(cmd_raw))
      atc_pkg::CMD_UPDATE: begin
        travel_update(pos);
        count_cycles();
      end
      atc_pkg::CMD_SET_CLOSE: if (allowed(1)) begin
        close_pt = pos;
        ends |= 1;
      end
      atc_pkg::CMD_CLR_CLOSE: if (allowed(0)) begin
        close_pt = 0;
        ends &= 2;
      end
      atc_pkg::CMD_SET_OPEN: if (allowed(2)) begin
        open_pt = pos;
        ends |= 2;
      end
      atc_pkg::CMD_CLR_OPEN: if (allowed(0)) begin
        open_pt = 0;
        ends &= 1;
      end
      atc_pkg::CMD_OPEN_REVS: if (r != 0 && allowed(3)) begin
        close_pt = pos;
        d = revs_to_counts(r);
        open_pt = ((rev_dir != 0) ? pos - d : pos + d) & PosMask;
        ends = 3;
      end
      atc_pkg::CMD_CLOSE_REVS: if (r != 0 && allowed(3)) begin
        open_pt = pos;
        d = revs_to_counts(r);
        close_pt = ((rev_dir != 0) ? pos + d : pos - d) & PosMask;
        ends = 3;
      end
      default: ;
    endcase
    s.pct = pct_r[15:0];
    s.cway = cur_way_r[15:0];
    s.fway = full_way_r[15:0];
    s.zone = zone_r[1:0];
    s.ends = ends[1:0];
    s.cancel = cancel_r[0];
    s.cycles = cycles[15:0];
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t want, got;
    if (!rst_ni) begin
      gear = 1000; shift = 0; tol = 5; rev_dir = 0; lock = 0;
      close_pt = 0; open_pt = 0; ends = 0; full_trav = 0; mid_pt = 0; trav_close = 0;
      full_way_r = 0; cur_way_r = 0; pct_r = 0;
      tracker = 0; cycles = 0; cancel_r = 0; zone_r = 0;
      status_q.delete();
      errors_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (atc_pkg::cfg_idx_e'(cfg_index_i))
          atc_pkg::CFG_GEAR:     gear = longint'(cfg_data_i);
          atc_pkg::CFG_SHIFT:    shift = longint'(cfg_data_i[3:0]);
          atc_pkg::CFG_TOL:      tol = longint'(cfg_data_i);
          atc_pkg::CFG_REVERSED: rev_dir = longint'(cfg_data_i[0]);
          atc_pkg::CFG_LOCK:     lock = longint'(cfg_data_i[0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{percent_position_i, current_way_i, full_way_i, zone_i, calib_status_i,
                cancelled_i, cycle_count_i};
        checked_o++;
        if (status_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("error: unexpected result transaction %p", got);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("error: result %0d mismatch", checked_o);
              $display("  expected pct=%0d way=%0d full=%0d zone=%0d ends=%0d cancel=%0d cyc=%0d",
                       $signed(want.pct), $signed(want.cway), want.fway, want.zone,
                       want.ends, want.cancel, want.cycles);
              $display("  actual   pct=%0d way=%0d full=%0d zone=%0d ends=%0d cancel=%0d cyc=%0d",
                       $signed(got.pct), $signed(got.cway), got.fway, got.zone,
                       got.ends, got.cancel, got.cycles);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i)
        status_q.push_back(predict_status(command_i, abs_position_i, revolutions_i));
    end
    pending_o = status_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         command = '0;
  logic [23:0]        abs_position = '0;
  logic [15:0]        revolutions = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] percent_position;
  logic signed [15:0] current_way;
  logic [15:0]        full_way;
  logic [1:0]         zone;
  logic [1:0]         calib_status;
  logic               cancelled;
  logic [15:0]        cycle_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  int errors, pending, checked;
  int cycle_cnt = 0;
  int burst_left = 0;
  int settings = 0;
  logic in_ready_s, cfg_ready_s;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  actuator_travel_calibration_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .abs_position_i(abs_position), .revolutions_i(revolutions),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .percent_position_o(percent_position), .current_way_o(current_way),
    .full_way_o(full_way), .zone_o(zone), .calib_status_o(calib_status),
    .cancelled_o(cancelled), .cycle_count_o(cycle_count),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  atc_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .command_i(command), .abs_position_i(abs_position), .revolutions_i(revolutions),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .percent_position_i(percent_position), .current_way_i(current_way),
    .full_way_i(full_way), .zone_i(zone), .calib_status_i(calib_status),
    .cancelled_i(cancelled), .cycle_count_i(cycle_count),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  // ready levels are stable by the falling edge
  always @(negedge clk) begin
    in_ready_s = in_ready;
    cfg_ready_s = cfg_ready;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall pattern, cycling through four modes
  always @(posedge clk) begin
    int mode;
    mode = (cycle_cnt >> 8) % 4;
    case (mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ((cycle_cnt % 16) == 0);
      default: out_ready <= ($urandom_range(0, 5) != 0);
    endcase
  end

  task automatic send_item(atc_pkg::cmd_e c, logic [23:0] p, logic [15:0] r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    command <= c;
    abs_position <= p;
    revolutions <= r;
    @(posedge clk);
    while (!in_ready_s) @(posedge clk);
    burst_left--;
  endtask

  // let every result come back, then the divider latency on top
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic cfg_write(atc_pkg::cfg_idx_e idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready_s) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // unlock again after the locked phase
  task automatic cfg_write_after_settle();
    settle();
    cfg_write(atc_pkg::CFG_LOCK, 16'd0);
  endtask

  // one calibrate-and-sweep sequence with random content
  task automatic travel_sweep();
    logic [23:0] cl, span, p;
    int n;
    cl = 24'($urandom());
    span = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(16, 1 << 18));
    send_item(atc_pkg::CMD_CLR_CLOSE, 24'($urandom()), 16'($urandom()));
    send_item(atc_pkg::CMD_CLR_OPEN, 24'($urandom()), 16'($urandom()));
    case ($urandom_range(0, 3))
      0: send_item(atc_pkg::CMD_OPEN_REVS, cl, 16'($urandom_range(1, 3000)));
      1: send_item(atc_pkg::CMD_CLOSE_REVS, cl, 16'($urandom_range(1, 3000)));
      default: begin
        send_item(atc_pkg::CMD_SET_CLOSE, cl, 16'($urandom()));
        send_item(atc_pkg::CMD_UPDATE, 24'(cl + $urandom_range(0, 40)), 16'($urandom()));
        send_item(atc_pkg::CMD_SET_OPEN, cl + span, 16'($urandom()));
      end
    endcase
    n = $urandom_range(4, 14);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: p = 24'($urandom());
        1: p = 24'(cl - $urandom_range(0, 64));
        2: p = 24'(cl + span + $urandom_range(0, 64));
        3: p = 24'(cl + $urandom_range(0, 8));
        4: p = 24'(cl + span - $urandom_range(0, 8));
        default: p = 24'(cl + $urandom_range(0, span));
      endcase
      if ($urandom_range(0, 15) == 0)
        send_item(atc_pkg::cmd_e'($urandom_range(1, 7)), p, 16'($urandom()));
      else
        send_item(atc_pkg::CMD_UPDATE, p, 16'($urandom()));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset configuration
    send_item(atc_pkg::CMD_UPDATE, 24'h000123, 16'h0000);
    send_item(atc_pkg::CMD_SET_CLOSE, 24'h000000, 16'hFFFF);
    send_item(atc_pkg::CMD_UPDATE, 24'h000003, 16'h0000);
    send_item(atc_pkg::CMD_UPDATE, 24'hFFFFFF, 16'h0000);
    send_item(atc_pkg::CMD_SET_CLOSE, 24'h000010, 16'h0000);
    send_item(atc_pkg::CMD_OPEN_REVS, 24'h000010, 16'h0000);
    send_item(atc_pkg::CMD_OPEN_REVS, 24'h000010, 16'h0001);
    send_item(atc_pkg::cmd_e'(3'd7), 24'hFFFFFF, 16'hFFFF);
    send_item(atc_pkg::CMD_SET_OPEN, 24'h000004, 16'h0000);
    send_item(atc_pkg::CMD_UPDATE, 24'h000002, 16'h0000);
    send_item(atc_pkg::CMD_CLR_OPEN, 24'h000000, 16'h0000);
    send_item(atc_pkg::CMD_SET_OPEN, 24'h000800, 16'h0000);
    send_item(atc_pkg::CMD_UPDATE, 24'h000000, 16'h0000);
    send_item(atc_pkg::CMD_UPDATE, 24'h000400, 16'h0000);
    send_item(atc_pkg::CMD_UPDATE, 24'h000801, 16'h0000);
    send_item(atc_pkg::CMD_UPDATE, 24'h000000, 16'h0000);
    send_item(atc_pkg::CMD_UPDATE, 24'h000800, 16'h0000);
    send_item(atc_pkg::CMD_CLR_CLOSE, 24'h000000, 16'h0000);
    send_item(atc_pkg::CMD_UPDATE, 24'h000700, 16'h0000);
    send_item(atc_pkg::CMD_CLR_OPEN, 24'h000000, 16'h0000);
    send_item(atc_pkg::CMD_CLOSE_REVS, 24'hFFFFFF, 16'hFFFF);
    send_item(atc_pkg::CMD_UPDATE, 24'h800000, 16'h0000);
    send_item(atc_pkg::CMD_UPDATE, 24'hABCDEF, 16'h0000);
    settle();
    settings++;

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          cfg_write(atc_pkg::CFG_GEAR, 16'd1);
          cfg_write(atc_pkg::CFG_SHIFT, 16'd0);
          cfg_write(atc_pkg::CFG_TOL, 16'd0);
        end
        1: begin
          cfg_write(atc_pkg::CFG_GEAR, 16'hFFFF);
          cfg_write(atc_pkg::CFG_SHIFT, 16'd15);
          cfg_write(atc_pkg::CFG_TOL, 16'hFFFF);
          cfg_write(atc_pkg::CFG_REVERSED, 16'd1);
        end
        2: begin
          // gear ratio of zero counts as one in the way arithmetic
          cfg_write(atc_pkg::CFG_GEAR, 16'd0);
          cfg_write(atc_pkg::CFG_TOL, 16'd3);
          cfg_write(atc_pkg::CFG_LOCK, 16'd1);
        end
        default: begin
          cfg_write(atc_pkg::CFG_GEAR, 16'($urandom_range(1, 65535)));
          cfg_write(atc_pkg::CFG_SHIFT, 16'($urandom_range(0, 15)));
          cfg_write(atc_pkg::CFG_TOL, 16'($urandom_range(0, 40)));
          cfg_write(atc_pkg::CFG_REVERSED, 16'($urandom_range(0, 1)));
          cfg_write(atc_pkg::CFG_LOCK, 16'($urandom_range(0, 5) == 0));
        end
      endcase
      settings++;
      for (int s = 0; s < 4; s++) travel_sweep();
      for (int k = 0; k < 6; k++)
        send_item(atc_pkg::cmd_e'($urandom_range(0, 7)), 24'($urandom()), 16'($urandom()));
      if (ph == 2) cfg_write_after_settle();
      settle();
    end

    $display("covered %0d result transactions over %0d register settings", checked, settings);
    $display("mismatches: %0d", errors);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/atc_pkg.sv
hw/rtl/atc_div.sv
hw/rtl/actuator_travel_calibration_core.sv
tb/atc_checker.sv
tb/tb_top.sv
